// ----- rtl/matrix_inverse_3x3_macros.svh -----
// Assertion helpers shared by the block's modules.
// Each one samples on clock and stays quiet while reset is high.
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MI3_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mi3_pkg.sv -----
package mi3_pkg;

   localparam int DATA_W        = 32;
   localparam int N_ENT         = 9;
   localparam int FRAC_BITS_DEF = 16;
   localparam int EPS_W         = 31;
   localparam int COF_W         = 2 * DATA_W + 1;
   localparam int DET_W         = 3 * DATA_W + 3;
   localparam int DM_W          = DET_W - 1;
   localparam int QUO_BITS      = DATA_W + 1;
   localparam int PRE_LAT       = 6;
   localparam int DIV_LAT       = QUO_BITS + 2;
   localparam int PIPE_LAT      = PRE_LAT + DIV_LAT;

   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

   typedef logic signed [DATA_W-1:0] entry_type;
   typedef logic signed [COF_W-1:0]  cof_type;
   typedef logic [DM_W-1:0]          dmag_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } quo_type;

   typedef struct packed {
      logic singular;
      logic det_sat;
   } flags_type;

   // Operands of each adjugate entry: cof = m[x] * m[y] - m[u] * m[w], row-major.
   localparam int COF_SEL [N_ENT][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

endpackage

// ----- rtl/mi3_cof.sv -----
module mi3_cof (
   input  logic               clock,
   input  logic               en,
   input  mi3_pkg::entry_type x_i,
   input  mi3_pkg::entry_type y_i,
   input  mi3_pkg::entry_type u_i,
   input  mi3_pkg::entry_type w_i,
   output mi3_pkg::cof_type   cof_o
);
   import mi3_pkg::*;

   logic signed [2*DATA_W-1:0] p1_ff, p2_ff, p1_in, p2_in;
   cof_type                    cof_ff, cof_in;

   assign p1_in  = x_i * y_i;
   assign p2_in  = u_i * w_i;
   assign cof_in = COF_W'(p1_ff) - COF_W'(p2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         cof_ff <= cof_in;
      end
   end

   assign cof_o = cof_ff;

endmodule

// ----- rtl/mi3_div.sv -----
module mi3_div #(
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          en,
   input  logic [2*mi3_pkg::DATA_W+2*FRAC_BITS-1:0]      nm_i,
   input  mi3_pkg::dmag_type                             dm_i,
   input  logic                                          neg_i,
   output mi3_pkg::quo_type                              quo_o
);
   import mi3_pkg::*;

   localparam int R_W = DM_W + QUO_BITS + 1;
   localparam logic [QUO_BITS:0] NEG_LIM = (QUO_BITS + 1)'(1) << (DATA_W - 1);

   logic [R_W-1:0]      rem_ff  [QUO_BITS+1];
   logic [QUO_BITS-1:0] q_ff    [QUO_BITS+1];
   dmag_type            dm_ff   [QUO_BITS+1];
   logic                neg_ff  [QUO_BITS+1];
   logic                over_ff [QUO_BITS+1];

   logic [R_W-1:0]    nm_ext_in, dm_top_in;
   logic              over_in;
   logic [R_W:0]      rem2_in;
   logic              rnd_in, clip_in;
   logic [QUO_BITS:0] qr_in;
   logic [DATA_W-1:0] neg_val_in;
   quo_type           quo_ff, quo_in;

   // A quotient of 2^QUO_BITS or more clips whatever its sign.
   assign nm_ext_in = R_W'(nm_i);
   assign dm_top_in = R_W'(dm_i) << QUO_BITS;
   assign over_in   = nm_ext_in >= dm_top_in;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= nm_ext_in;
         q_ff[0]    <= '0;
         dm_ff[0]   <= dm_i;
         neg_ff[0]  <= neg_i;
         over_ff[0] <= over_in;
      end
   end

   for (genvar k = 1; k <= QUO_BITS; k++) begin : g_step
      logic [R_W-1:0]      dsh_in, rem_in;
      logic [QUO_BITS-1:0] q_in;
      logic                take_in;

      assign dsh_in  = R_W'(dm_ff[k-1]) << (QUO_BITS - k);
      assign take_in = rem_ff[k-1] >= dsh_in;
      assign rem_in  = take_in ? rem_ff[k-1] - dsh_in : rem_ff[k-1];
      assign q_in    = q_ff[k-1] | (take_in ? (QUO_BITS'(1) << (QUO_BITS - k)) : '0);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            q_ff[k]    <= q_in;
            dm_ff[k]   <= dm_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            over_ff[k] <= over_ff[k-1];
         end
      end
   end

   // Round to nearest with ties away from zero, on the magnitude.
   assign rem2_in    = {rem_ff[QUO_BITS], 1'b0};
   assign rnd_in     = rem2_in >= (R_W + 1)'(dm_ff[QUO_BITS]);
   assign qr_in      = {1'b0, q_ff[QUO_BITS]} + (QUO_BITS + 1)'(rnd_in);
   assign neg_val_in = DATA_W'(0) - qr_in[DATA_W-1:0];

   always_comb begin
      if (neg_ff[QUO_BITS]) begin
         clip_in      = over_ff[QUO_BITS] || (qr_in > NEG_LIM);
         quo_in.value = clip_in ? {1'b1, {(DATA_W - 1){1'b0}}} : neg_val_in;
      end else begin
         clip_in      = over_ff[QUO_BITS] || (qr_in >= NEG_LIM);
         quo_in.value = clip_in ? {1'b0, {(DATA_W - 1){1'b1}}} : qr_in[DATA_W-1:0];
      end
      quo_in.sat = clip_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo_o = quo_ff;

endmodule

// ----- rtl/matrix_inverse_3x3.sv -----
// 3x3 matrix inverse in signed fixed point, one matrix per word.
// req_*: one word carries the nine entries; rsp_*: one word carries the inverse
// with the singular and saturated flags in rsp_tuser. csr_*: writes the
// singular threshold (always ready, write only while no matrix is in flight).
// Nine cofactor lanes run side by side, a shared determinant path follows,
// then nine divider lanes each resolve one quotient bit per stage, and the
// last stage merges the lane flags into the result word.
// From acceptance to rsp_tvalid a matrix passes the pipeline stages and then
// the output register; the divider lanes set most of the pipeline, one stage
// per quotient bit (33) plus a range check and a rounding stage.
// Throughput is one matrix per cycle while rsp_tready stays high.
// When the receiver stalls, the finished word is held in the output register;
// the pipeline keeps moving to close empty slots and stops only once its
// last stage also holds a word, at which point req_tready drops.
// Synchronous reset empties the pipeline and the output register and sets the
// threshold to one least significant bit.
`include "matrix_inverse_3x3_macros.svh"

module matrix_inverse_3x3 #(
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // a00, a01, a02, a10, a11, a12, a20, a21, a22 from the lowest bit up
   input  logic [mi3_pkg::N_ENT*mi3_pkg::DATA_W-1:0] req_tdata,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22
   output logic [mi3_pkg::N_ENT*mi3_pkg::DATA_W-1:0] rsp_tdata,
   // singular, saturated from the lowest bit up
   output logic [1:0]                                rsp_tuser,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // singular_epsilon in the low bits, top bit unused
   input  logic [mi3_pkg::DATA_W-1:0]                csr_tdata,
   input  logic                                      csr_tvalid,
   output logic                                      csr_tready
);
   import mi3_pkg::*;

   localparam int NM_W = 2 * DATA_W + 2 * FRAC_BITS;
   localparam int PH_W = DATA_W + (COF_W - DATA_W) + 1;

   entry_type m_in [N_ENT];
   cof_type   cof_s2 [N_ENT];
   cof_type   cof_s3_ff [N_ENT];
   cof_type   cof_s4_ff [N_ENT];
   cof_type   cof_s5_ff [N_ENT];
   entry_type row0_s1_ff [3];
   entry_type row0_s2_ff [3];

   logic signed [PH_W-1:0]  plo_ff [3];
   logic signed [PH_W-1:0]  phi_ff [3];
   logic signed [DET_W-1:0] t_ff [3];
   logic signed [DET_W-1:0] det_ff;

   logic [NM_W-1:0] nm_ff [N_ENT];
   logic            neg_ff [N_ENT];
   dmag_type        dm_ff, dm_in;
   flags_type       fl_ff [DIV_LAT+1];
   flags_type       fl_in;
   quo_type         quo [N_ENT];

   logic [PIPE_LAT-1:0] v_ff, v_in;
   logic [EPS_W-1:0]    eps_ff, eps_in;
   logic                pipe_en, out_free;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [N_ENT*DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]          rsp_user_ff, rsp_user_in;
   logic                any_sat_in;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign pipe_en    = out_free || !v_ff[PIPE_LAT-1];
   assign req_tready = pipe_en;
   assign csr_tready = 1'b1;

   for (genvar k = 0; k < N_ENT; k++) begin : g_unpack
      assign m_in[k] = req_tdata[k*DATA_W +: DATA_W];
   end

   // Stages 1 and 2: one cofactor per lane.
   for (genvar k = 0; k < N_ENT; k++) begin : g_cof
      mi3_cof u_cof (
         .clock (clock),
         .en    (pipe_en),
         .x_i   (m_in[COF_SEL[k][0]]),
         .y_i   (m_in[COF_SEL[k][1]]),
         .u_i   (m_in[COF_SEL[k][2]]),
         .w_i   (m_in[COF_SEL[k][3]]),
         .cof_o (cof_s2[k])
      );
   end

   // Stages 3 to 5: determinant along row 0. Each 32 x 65 product is split
   // into a low unsigned half and a signed high half of the cofactor.
   for (genvar j = 0; j < 3; j++) begin : g_det
      logic signed [PH_W-1:0]  plo_in, phi_in;
      logic signed [DET_W-1:0] t_in;

      assign plo_in = row0_s2_ff[j] * $signed({1'b0, cof_s2[3*j][DATA_W-1:0]});
      assign phi_in = row0_s2_ff[j] * $signed(cof_s2[3*j][COF_W-1:DATA_W]);
      assign t_in   = (DET_W'(phi_ff[j]) <<< DATA_W) + DET_W'(plo_ff[j]);

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            row0_s1_ff[j] <= m_in[j];
            row0_s2_ff[j] <= row0_s1_ff[j];
            plo_ff[j]     <= plo_in;
            phi_ff[j]     <= phi_in;
            t_ff[j]       <= t_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         det_ff <= t_ff[0] + t_ff[1] + t_ff[2];
      end
   end

   // Stage 6: magnitudes, signs and the singular and range checks.
   assign dm_in = det_ff[DET_W-1] ? DM_W'(-det_ff) : DM_W'(det_ff);

   always_comb begin
      fl_in.singular = (dm_in == '0) || (dm_in < (DM_W'(eps_ff) << (2 * FRAC_BITS)));
      if (det_ff[DET_W-1]) begin
         fl_in.det_sat = dm_in > (DM_W'(1) << (DATA_W - 1 + 2 * FRAC_BITS));
      end else begin
         fl_in.det_sat = dm_in >= (DM_W'(1) << (DATA_W - 1 + 2 * FRAC_BITS));
      end
   end

   for (genvar k = 0; k < N_ENT; k++) begin : g_lane
      logic [COF_W-1:0] cabs_in;
      logic [NM_W-1:0]  nm_in;

      assign cabs_in = cof_s5_ff[k][COF_W-1] ? -cof_s5_ff[k] : cof_s5_ff[k];
      assign nm_in   = NM_W'(cabs_in[COF_W-2:0]) << (2 * FRAC_BITS);

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            cof_s3_ff[k] <= cof_s2[k];
            cof_s4_ff[k] <= cof_s3_ff[k];
            cof_s5_ff[k] <= cof_s4_ff[k];
            nm_ff[k]     <= nm_in;
            neg_ff[k]    <= cof_s5_ff[k][COF_W-1] ^ det_ff[DET_W-1];
         end
      end

      mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock),
         .en    (pipe_en),
         .nm_i  (nm_ff[k]),
         .dm_i  (dm_ff),
         .neg_i (neg_ff[k]),
         .quo_o (quo[k])
      );
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dm_ff    <= dm_in;
         fl_ff[0] <= fl_in;
      end
   end

   for (genvar d = 1; d <= DIV_LAT; d++) begin : g_flags
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            fl_ff[d] <= fl_ff[d-1];
         end
      end
   end

   // Merge: the lanes' clip flags join the determinant range flag.
   always_comb begin
      any_sat_in = fl_ff[DIV_LAT].det_sat;
      for (int k = 0; k < N_ENT; k++) begin
         any_sat_in = any_sat_in | quo[k].sat;
         rsp_data_in[k*DATA_W +: DATA_W] =
            fl_ff[DIV_LAT].singular ? '0 : quo[k].value;
      end
      rsp_user_in = {any_sat_in & !fl_ff[DIV_LAT].singular, fl_ff[DIV_LAT].singular};
   end

   assign v_in          = pipe_en ? {v_ff[PIPE_LAT-2:0], req_tvalid} : v_ff;
   assign rsp_tvalid_in = out_free ? v_ff[PIPE_LAT-1] : rsp_tvalid_ff;
   assign eps_in        = (csr_tvalid && csr_tready) ? csr_tdata[EPS_W-1:0] : eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
         eps_ff        <= EPS_RESET;
      end else begin
         v_ff          <= v_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         eps_ff        <= eps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `MI3_ASSERT_IMPL(a_sing_no_sat, rsp_tvalid && rsp_tuser[0], !rsp_tuser[1], "singular word flagged saturated")
   `MI3_ASSERT_IMPL(a_sing_zero, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0, "singular word carries nonzero data")
   `MI3_ASSERT_IMPL(a_stall_cause, !req_tready, v_ff[PIPE_LAT-1] && rsp_tvalid && !rsp_tready, "input stalled without a full pipeline end")
   `MI3_ASSERT_NEXT(a_csr_write, csr_tvalid && csr_tready, eps_ff == $past(csr_tdata[EPS_W-1:0]), "threshold write lost")

endmodule
